### rtl/core/bpfa_pkg.sv
// shared types and codes for the bitmap page frame allocator
`timescale 1ns / 1ps
package bpfa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_MARK  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFREE   = 3'd1,
        ST_MISALIGN = 3'd2,
        ST_RANGE    = 3'd3,
        ST_DOUBLE   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MOD,
        S_READ,
        S_EVAL,
        S_RESULT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic mod_step;
        logic rd;
        logic eval;
        logic out_load;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic direct;
        logic need_mod;
        logic mod_last;
        logic eval_done;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/core/bpfa_req_if.sv
// request channel interface
`timescale 1ns / 1ps
interface bpfa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [31:0] end_addr;
    logic [11:0] page_sel;

    modport source (output valid, cmd, addr, end_addr, page_sel, input ready);
    modport sink (input valid, cmd, addr, end_addr, page_sel, output ready);
endinterface

### rtl/core/bpfa_rsp_if.sv
// response channel interface
`timescale 1ns / 1ps
interface bpfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [23:0] page_addr;
    logic        page_free;
    logic [12:0] free_count;

    modport source (output valid, status, page_addr, page_free, free_count, input ready);
    modport sink (input valid, status, page_addr, page_free, free_count, output ready);
endinterface

### rtl/core/bpfa_cfg_if.sv
// configuration write channel interface
`timescale 1ns / 1ps
interface bpfa_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### rtl/core/bpfa_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/core/bpfa_ctrl.sv
// controller state machine of the page allocator
`timescale 1ns / 1ps
module bpfa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bpfa_pkg::dp_status_t st,
    output bpfa_pkg::ctrl_cmd_t  cmd
);
    import bpfa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                if (st.direct)
                begin
                    state_next = S_RESULT;
                end
                else if (st.need_mod)
                begin
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (st.mod_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = st.eval_done ? S_RESULT : S_READ;
            end
            S_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

### rtl/core/bpfa_datapath.sv
// datapath: free map rows, counters, hint, scan and result registers
`timescale 1ns / 1ps
module bpfa_datapath #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           req_cmd,
    input  logic [31:0]          req_addr,
    input  logic [31:0]          req_end_addr,
    input  logic [11:0]          req_page_sel,
    input  logic                 cfg_valid,
    input  logic [12:0]          cfg_data,
    input  bpfa_pkg::ctrl_cmd_t  cmd,
    output bpfa_pkg::dp_status_t st,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [2:0]           rsp_status,
    output logic [23:0]          rsp_page_addr,
    output logic                 rsp_page_free,
    output logic [12:0]          rsp_free_count
);
    import bpfa_pkg::*;

    localparam int WW   = (MAX_PAGES < 64) ? MAX_PAGES : 64;
    localparam int ROWS = MAX_PAGES / WW;
    localparam int BW   = $clog2(WW);
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW   = $clog2(MAX_PAGES);
    localparam int CW   = PW + 1;
    localparam int VW   = RW + 1;
    localparam int IW   = $clog2(PW);
    localparam int LPB  = $clog2(PAGE_BYTES);

    // request and state registers
    cmd_t              cmd_reg;
    logic [31:0]       addr_reg;
    logic [31:0]       end_reg;
    logic [11:0]       qidx_reg;
    logic [12:0]       pc_reg;
    logic [PW-1:0]     hint_reg;
    logic [CW-1:0]     total_reg;
    logic [PW-1:0]     pos_reg;
    logic [RW-1:0]     row_reg;
    logic [VW-1:0]     visits_reg;
    logic              first_reg;
    logic [CW-1:0]     rem_reg;
    logic [IW-1:0]     mcnt_reg;
    logic [(1<<RW)-1:0] row_valid_reg;
    status_t           res_status_reg;
    logic [23:0]       res_paddr_reg;
    logic              res_pfree_reg;
    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [23:0]       out_paddr_reg;
    logic              out_pfree_reg;
    logic [12:0]       out_count_reg;

    // combinational signals
    logic [31:0]   n32;
    logic [31:0]   ps32;
    logic [31:0]   pe_raw;
    logic [31:0]   pe32;
    logic [31:0]   nl32;
    logic [31:0]   el32;
    logic [RW-1:0] nl_row;
    logic [BW-1:0] nl_bit;
    logic [RW-1:0] el_row;
    logic [BW-1:0] el_bit;
    logic [RW-1:0] pos_row;
    logic [BW-1:0] pos_bit;
    logic          misalign;
    logic [WW-1:0] ones;
    logic [WW-1:0] rdata;
    logic [WW-1:0] d;
    logic [WW-1:0] lim_mask;
    logic [WW-1:0] lo_mask;
    logic [WW-1:0] el_mask;
    logic [WW-1:0] cand;
    logic [WW-1:0] mclr;
    logic          found;
    logic [BW-1:0] fb;
    logic [31:0]   idx32;
    logic [CW:0]   mod_t;
    logic [CW:0]   mod_r;
    logic          we;
    logic [WW-1:0] wdata;
    logic          eval_done;

    assign ones     = '1;
    assign n32      = ({19'b0, pc_reg} > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : {19'b0, pc_reg};
    assign ps32     = addr_reg >> LPB;
    assign pe_raw   = end_reg >> LPB;
    assign pe32     = (pe_raw > n32) ? n32 : pe_raw;
    assign nl32     = n32 - 32'd1;
    assign el32     = pe32 - 32'd1;
    assign nl_row   = RW'(nl32 >> BW);
    assign nl_bit   = nl32[BW-1:0];
    assign el_row   = RW'(el32 >> BW);
    assign el_bit   = el32[BW-1:0];
    assign pos_row  = RW'(32'(pos_reg) >> BW);
    assign pos_bit  = pos_reg[BW-1:0];
    assign misalign = addr_reg[LPB-1:0] != '0;

    // status toward the controller
    always_comb
    begin
        st          = '0;
        st.out_free = !out_valid_reg || rsp_ready;
        st.mod_last = mcnt_reg == '0;
        st.eval_done = eval_done;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                st.direct   = n32 == 32'd0;
                st.need_mod = 32'(hint_reg) >= n32;
            end
            CMD_FREE:  st.direct = misalign || (ps32 >= n32);
            CMD_MARK:  st.direct = ps32 >= pe32;
            default:   st.direct = {20'b0, qidx_reg} >= n32;
        endcase
    end

    // row read with never written rows seen as all used
    bpfa_ram #(
        .WIDTH (WW),
        .DEPTH (ROWS)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (row_reg),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (row_reg),
        .rdata (rdata)
    );
    assign d = row_valid_reg[row_reg] ? rdata : '0;

    // masks for the scanned row
    assign lim_mask = (row_reg == nl_row) ? ~((ones << nl_bit) << 1) : ones;
    assign lo_mask  = (row_reg == pos_row) ? (ones << pos_bit) : ones;
    assign el_mask  = (row_reg == el_row) ? ~((ones << el_bit) << 1) : ones;
    assign cand     = d & lim_mask & (first_reg ? lo_mask : ones);
    assign mclr     = lo_mask & el_mask;
    assign found    = cand != '0;
    assign idx32    = (32'(row_reg) << BW) | 32'(fb);

    // lowest free bit of the row
    always_comb
    begin
        fb = '0;
        for (int b = WW - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                fb = BW'(b);
            end
        end
    end

    // one step of hint reduction modulo the page count
    assign mod_t = {rem_reg, hint_reg[mcnt_reg]};
    assign mod_r = (mod_t >= (CW+1)'(n32)) ? (mod_t - (CW+1)'(n32)) : mod_t;

    // row write and completion per command
    always_comb
    begin
        we        = 1'b0;
        wdata     = d;
        eval_done = 1'b1;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                we        = cmd.eval && found;
                wdata     = d & ~(WW'(1) << fb);
                eval_done = found || (visits_reg == VW'(nl_row) + VW'(1));
            end
            CMD_FREE:
            begin
                we    = cmd.eval && !d[pos_bit];
                wdata = d | (WW'(1) << pos_bit);
            end
            CMD_MARK:
            begin
                we        = cmd.eval;
                wdata     = d & ~mclr;
                eval_done = row_reg == el_row;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= 13'd4096;
            hint_reg      <= '0;
            total_reg     <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                pc_reg <= cfg_data;
            end
            if (we)
            begin
                row_valid_reg[row_reg] <= 1'b1;
            end
            if (cmd.eval)
            begin
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (found)
                        begin
                            total_reg <= total_reg - CW'(1);
                            hint_reg  <= ((idx32 + 32'd1) == n32) ? '0 : PW'(idx32 + 32'd1);
                        end
                    end
                    CMD_FREE:
                    begin
                        if (!d[pos_bit])
                        begin
                            total_reg <= total_reg + CW'(1);
                        end
                    end
                    CMD_MARK:
                    begin
                        total_reg <= total_reg - CW'($countones(d & mclr));
                    end
                    default:
                    begin
                        total_reg <= total_reg;
                    end
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, scan position and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= cmd_t'(req_cmd);
            addr_reg <= req_addr;
            end_reg  <= req_end_addr;
            qidx_reg <= req_page_sel;
        end
        if (cmd.setup)
        begin
            res_status_reg <= ST_OK;
            res_paddr_reg  <= '0;
            res_pfree_reg  <= 1'b0;
            visits_reg     <= '0;
            first_reg      <= 1'b1;
            rem_reg        <= '0;
            mcnt_reg       <= IW'(PW - 1);
            case (cmd_reg)
                CMD_ALLOC:
                begin
                    pos_reg <= hint_reg;
                    row_reg <= RW'(32'(hint_reg) >> BW);
                    if (n32 == 32'd0)
                    begin
                        res_status_reg <= ST_NOFREE;
                    end
                end
                CMD_FREE:
                begin
                    pos_reg <= PW'(ps32);
                    row_reg <= RW'(ps32 >> BW);
                    if (misalign)
                    begin
                        res_status_reg <= ST_MISALIGN;
                    end
                    else if (ps32 >= n32)
                    begin
                        res_status_reg <= ST_RANGE;
                    end
                end
                CMD_MARK:
                begin
                    pos_reg <= PW'(ps32);
                    row_reg <= RW'(ps32 >> BW);
                end
                default:
                begin
                    pos_reg <= PW'(qidx_reg);
                    row_reg <= RW'({20'b0, qidx_reg} >> BW);
                end
            endcase
        end
        if (cmd.mod_step)
        begin
            rem_reg  <= CW'(mod_r);
            mcnt_reg <= mcnt_reg - IW'(1);
            if (mcnt_reg == '0)
            begin
                pos_reg <= PW'(mod_r);
                row_reg <= RW'(32'(mod_r) >> BW);
            end
        end
        if (cmd.eval)
        begin
            case (cmd_reg)
                CMD_ALLOC:
                begin
                    if (found)
                    begin
                        res_paddr_reg <= 24'(64'(idx32) << LPB);
                    end
                    else
                    begin
                        visits_reg <= visits_reg + VW'(1);
                        first_reg  <= 1'b0;
                        row_reg    <= (row_reg == nl_row) ? '0 : row_reg + RW'(1);
                        if (eval_done)
                        begin
                            res_status_reg <= ST_NOFREE;
                        end
                    end
                end
                CMD_FREE:
                begin
                    if (d[pos_bit])
                    begin
                        res_status_reg <= ST_DOUBLE;
                    end
                end
                CMD_MARK:
                begin
                    row_reg <= row_reg + RW'(1);
                end
                default:
                begin
                    res_pfree_reg <= d[pos_bit];
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_paddr_reg  <= res_paddr_reg;
            out_pfree_reg  <= res_pfree_reg;
            out_count_reg  <= 13'(32'(total_reg));
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_page_addr  = out_paddr_reg;
    assign rsp_page_free  = out_pfree_reg;
    assign rsp_free_count = out_count_reg;
endmodule

### rtl/core/bitmap_page_frame_allocator_core.sv
// path from the accept cycle to the first response cycle: a direct error, a query out of
// range or an empty mark goes from setup to result; free and query read and evaluate one
// row; mark reads and evaluates each touched row; allocate does the same per scanned row, up
// to rows + 1 rows, after a hint reduction when the hint lies at or above the page count
// one request at a time: the next is taken once the last result is loaded into the output
// register, which lets it in while a response waits
// reset: every page used, free count and hint zero, page count 4096, no clearing pass
`timescale 1ns / 1ps
module bitmap_page_frame_allocator_core #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    bpfa_req_if.sink      req,
    bpfa_rsp_if.source    rsp,
    bpfa_cfg_if.sink      cfg
);
    import bpfa_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // configuration is always taken
    assign cfg.ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    bpfa_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_cmd        (req.cmd),
        .req_addr       (req.addr),
        .req_end_addr   (req.end_addr),
        .req_page_sel   (req.page_sel),
        .cfg_valid      (cfg.valid),
        .cfg_data       (cfg.data),
        .cmd            (cmd),
        .st             (st),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_page_addr  (rsp.page_addr),
        .rsp_page_free  (rsp.page_free),
        .rsp_free_count (rsp.free_count)
    );
endmodule
